### hw/rtl/ntgf_pkg.sv
// Package for the spectral tilt gain unit: item types, register and envelope codes,
// fixed-point constants, and the log2/exp2 helper functions.
// No dependencies.
`default_nettype none

package ntgf_pkg;

  localparam int unsigned FREQ_W     = 24;
  localparam int unsigned FRAC_BITS  = 28;
  localparam int unsigned LOG_W      = 33;  // Q5.28, integer part up to 23
  localparam int unsigned MANT_W     = 31;  // Q30 mantissa in [1,2)
  localparam int unsigned LOG_STAGES = 28;
  localparam int unsigned EXP_STAGES = 28;
  localparam int unsigned LC_CNT_W   = $clog2(LOG_STAGES);
  localparam int unsigned IP_W       = 6;   // integer part of the exp2 argument
  localparam int unsigned T_W        = 36;  // signed exp2 argument, Q28

  localparam logic [MANT_W-1:0] ONE_Q30  = MANT_W'(1) << 30;
  localparam logic [MANT_W-1:0] HALF_Q30 = MANT_W'(1) << 29;
  localparam logic [MANT_W-1:0] K45_Q30  = MANT_W'(802550955);

  localparam logic [31:0] GAIN_ONE = 32'h0001_0000;
  localparam logic [31:0] GAIN_MAX = 32'hFFFF_FFFF;

  localparam logic [FREQ_W-1:0] CENTER_RESET = FREQ_W'(16000);

  typedef enum logic [2:0] {
    ENV_WHITE   = 3'd0,
    ENV_PINK    = 3'd1,
    ENV_BROWN   = 3'd2,
    ENV_BLUE    = 3'd3,
    ENV_VIOLET  = 3'd4,
    ENV_PLUS45  = 3'd5,
    ENV_MINUS45 = 3'd6
  } ntgf_env_e;

  typedef enum logic [1:0] {
    CFG_CENTER   = 2'd0,
    CFG_ENVELOPE = 2'd1,
    CFG_REVERSE  = 2'd2
  } ntgf_cfg_idx_e;

  typedef enum logic [1:0] {
    LC_LOAD,
    LC_ITER,
    LC_DONE
  } ntgf_lc_state_e;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic              last_point;
  } ntgf_in_t;

  typedef struct packed {
    logic [31:0] gain;
    logic        saturated;
    logic        last_out;
  } ntgf_out_t;

  typedef struct packed {
    logic [4:0]        exponent;
    logic [MANT_W-1:0] mant;
  } ntgf_norm_t;

  // Leading-one position and mantissa scaled to Q30.
  function automatic ntgf_norm_t ntgf_normalize(logic [FREQ_W-1:0] x);
    ntgf_norm_t r;
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < int'(FREQ_W); i++) begin
      if (x[i]) n = 5'(i);
    end
    r.exponent = n;
    r.mant     = MANT_W'({7'd0, x} << (5'd30 - n));
    return r;
  endfunction

  // One squaring step of the log2 fraction: {result bit, next mantissa}.
  function automatic logic [MANT_W:0] ntgf_log_step(logic [MANT_W-1:0] m);
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     p;
    sq = m * m;
    p  = sq[2*MANT_W-1:30];
    if (p[MANT_W]) begin
      return {1'b1, p[MANT_W:1]};
    end
    return {1'b0, p[MANT_W-1:0]};
  endfunction

  function automatic logic [63:0] ntgf_isqrt(logic [63:0] a);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= a) r = c;
    end
    return r;
  endfunction

  // 2^(2^-idx) in Q30, each root taken from the previous one and truncated.
  function automatic logic [MANT_W-1:0] ntgf_root_q30(int unsigned idx);
    logic [63:0] t;
    t = 64'd1 << 31;
    for (int unsigned i = 1; i <= idx; i++) begin
      t = ntgf_isqrt(t << 30);
    end
    return t[MANT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/noise_tilt_gain_from_frequency_unit.sv
// Spectral tilt gain unit: gain = (frequency / center)^k as unsigned Q16.16.
// Depends on ntgf_pkg.
`default_nettype none

// One item enters per clock while in_stall_o is low. Each gain passes through an
// entry register, a normalize stage, 28 squaring stages of the log2, the difference
// against log2(center), the multiply by k, the exp2 argument stage, 28 root-multiply
// stages of the exp2 and the output register. A two-entry output buffer (output
// register plus skid) absorbs one result under out_stall_i; while the skid holds an
// item the pipeline stops and in_stall_o is high. log2(center) is held in a register
// and rebuilt by a small sequencer after reset and after every write of center_frequency;
// in_stall_o is high while it runs. Configuration is taken every cycle.
module noise_tilt_gain_from_frequency_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ntgf_pkg::ntgf_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ntgf_pkg::ntgf_out_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [23:0]         cfg_data_i
);

  localparam int unsigned LS = ntgf_pkg::LOG_STAGES;
  localparam int unsigned XS = ntgf_pkg::EXP_STAGES;
  localparam int unsigned MW = ntgf_pkg::MANT_W;
  localparam int unsigned LW = ntgf_pkg::LOG_W;
  localparam int unsigned FB = ntgf_pkg::FRAC_BITS;
  localparam int unsigned TW = ntgf_pkg::T_W;
  localparam int unsigned IW = ntgf_pkg::IP_W;

  localparam logic [TW-1:0] T_BIAS  = TW'(16) << FB;
  localparam logic [TW-1:0] T_LIMIT = TW'(32) << FB;
  localparam logic [63:0]   RND_E   = 64'd1 << 29;

  // ---------------- configuration ----------------
  logic [23:0] center_q;
  logic [2:0]  env_q;
  logic        rev_q;
  logic        cfg_we;
  logic        center_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign center_we   = cfg_we && (cfg_index_i == ntgf_pkg::CFG_CENTER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= ntgf_pkg::CENTER_RESET;
      env_q    <= ntgf_pkg::ENV_WHITE;
      rev_q    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        ntgf_pkg::CFG_CENTER:   center_q <= cfg_data_i;
        ntgf_pkg::CFG_ENVELOPE: env_q    <= cfg_data_i[2:0];
        ntgf_pkg::CFG_REVERSE:  rev_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Exponent magnitude (Q30) and sign.
  logic [MW-1:0] k_mag;
  logic          k_neg_raw;
  logic          k_neg;
  logic          k_zero;

  always_comb begin
    k_mag     = '0;
    k_neg_raw = 1'b0;
    unique case (env_q)
      ntgf_pkg::ENV_PINK:    begin k_mag = ntgf_pkg::HALF_Q30; k_neg_raw = 1'b1; end
      ntgf_pkg::ENV_BROWN:   begin k_mag = ntgf_pkg::ONE_Q30;  k_neg_raw = 1'b1; end
      ntgf_pkg::ENV_BLUE:    begin k_mag = ntgf_pkg::HALF_Q30; end
      ntgf_pkg::ENV_VIOLET:  begin k_mag = ntgf_pkg::ONE_Q30;  end
      ntgf_pkg::ENV_PLUS45:  begin k_mag = ntgf_pkg::K45_Q30;  end
      ntgf_pkg::ENV_MINUS45: begin k_mag = ntgf_pkg::K45_Q30;  k_neg_raw = 1'b1; end
      default: ;  // white and the unused code
    endcase
  end

  assign k_neg  = k_neg_raw ^ rev_q;
  assign k_zero = (k_mag == '0);

  // ---------------- log2(center) sequencer ----------------
  ntgf_pkg::ntgf_lc_state_e lc_state_q, lc_state_d;
  logic [ntgf_pkg::LC_CNT_W-1:0] lc_cnt_q;
  logic [MW-1:0]                 lc_m_q;
  logic [4:0]                    lc_int_q;
  logic [FB-1:0]                 lc_frac_q;
  logic                          lc_busy;
  logic                          lc_load;
  logic                          lc_iter;
  logic [MW:0]                   lc_step;
  logic [23:0]                   center_eff;
  ntgf_pkg::ntgf_norm_t          lc_norm;
  logic [LW-1:0]                 lc_log;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_state_q <= ntgf_pkg::LC_LOAD;
    end else begin
      lc_state_q <= lc_state_d;
    end
  end

  always_comb begin
    lc_state_d = lc_state_q;
    if (center_we) begin
      lc_state_d = ntgf_pkg::LC_LOAD;
    end else begin
      unique case (lc_state_q)
        ntgf_pkg::LC_LOAD: lc_state_d = ntgf_pkg::LC_ITER;
        ntgf_pkg::LC_ITER: begin
          if (lc_cnt_q == ntgf_pkg::LC_CNT_W'(LS - 1)) lc_state_d = ntgf_pkg::LC_DONE;
        end
        ntgf_pkg::LC_DONE: lc_state_d = ntgf_pkg::LC_DONE;
        default:           lc_state_d = ntgf_pkg::LC_LOAD;
      endcase
    end
  end

  always_comb begin
    lc_busy = 1'b1;
    lc_load = 1'b0;
    lc_iter = 1'b0;
    unique case (lc_state_q)
      ntgf_pkg::LC_LOAD: lc_load = 1'b1;
      ntgf_pkg::LC_ITER: lc_iter = 1'b1;
      ntgf_pkg::LC_DONE: lc_busy = 1'b0;
      default: ;
    endcase
  end

  assign center_eff = (center_q == '0) ? 24'd1 : center_q;
  assign lc_norm    = ntgf_pkg::ntgf_normalize(center_eff);
  assign lc_step    = ntgf_pkg::ntgf_log_step(lc_m_q);
  assign lc_log     = {lc_int_q, lc_frac_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_cnt_q <= '0;
    end else if (lc_load) begin
      lc_cnt_q <= '0;
    end else if (lc_iter) begin
      lc_cnt_q <= lc_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lc_load) begin
      lc_m_q    <= lc_norm.mant;
      lc_int_q  <= lc_norm.exponent;
      lc_frac_q <= '0;
    end else if (lc_iter) begin
      lc_m_q    <= lc_step[MW-1:0];
      lc_frac_q <= {lc_frac_q[FB-2:0], lc_step[MW]};
    end
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic skid_vld_q;
  logic in_accept;

  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q || lc_busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Entry register
  logic               e_vld_q;
  ntgf_pkg::ntgf_in_t e_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_accept) e_item_q <= in_item_i;
  end

  // ---------------- log2(frequency): normalize + 28 squaring stages ----------------
  logic [LS:0]   lg_vld_q;
  logic [LS:0]   lg_last_q;
  logic [LS:0]   lg_zero_q;
  logic [MW-1:0] lg_m_q   [LS];
  logic [LW-1:0] lg_res_q [LS+1];
  logic [MW:0]   lg_step  [LS];
  ntgf_pkg::ntgf_norm_t f_norm;

  assign f_norm = ntgf_pkg::ntgf_normalize(e_item_q.frequency);

  for (genvar j = 0; j < LS; j++) begin : g_log
    assign lg_step[j] = ntgf_pkg::ntgf_log_step(lg_m_q[j]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_vld_q <= '0;
    end else if (en) begin
      lg_vld_q <= {lg_vld_q[LS-1:0], e_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lg_last_q   <= {lg_last_q[LS-1:0], e_item_q.last_point};
      lg_zero_q   <= {lg_zero_q[LS-1:0], (e_item_q.frequency == '0)};
      lg_m_q[0]   <= f_norm.mant;
      lg_res_q[0] <= {f_norm.exponent, {FB{1'b0}}};
      for (int j = 1; j <= int'(LS); j++) begin
        lg_res_q[j] <= lg_res_q[j-1] | (LW'(lg_step[j-1][MW]) << (int'(LS) - j));
        if (j < int'(LS)) lg_m_q[j] <= lg_step[j-1][MW-1:0];
      end
    end
  end

  // ---------------- difference, multiply by k, exp2 argument ----------------
  logic [LW:0]   d_diff;
  logic          d_vld_q, d_last_q, d_zero_q, d_neg_q;
  logic [LW-1:0] d_mag_q;

  assign d_diff = {1'b0, lg_res_q[LS]} - {1'b0, lc_log};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q <= lg_vld_q[LS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_last_q <= lg_last_q[LS];
      d_zero_q <= lg_zero_q[LS];
      d_neg_q  <= d_diff[LW] ^ k_neg;
      d_mag_q  <= d_diff[LW] ? LW'(-d_diff) : d_diff[LW-1:0];
    end
  end

  logic        p_vld_q, p_last_q, p_zero_q, p_neg_q;
  logic [63:0] p_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en) begin
      p_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_last_q <= d_last_q;
      p_zero_q <= d_zero_q;
      p_neg_q  <= d_neg_q;
      p_prod_q <= d_mag_q * k_mag;
    end
  end

  logic [63:0]   p_rnd;
  logic [TW-1:0] t_em;
  logic [TW-1:0] t_val;
  logic          t_ovf;

  assign p_rnd = p_prod_q + RND_E;
  assign t_em  = TW'(p_rnd[63:30]);
  assign t_val = p_neg_q ? (T_BIAS - t_em) : (T_BIAS + t_em);
  assign t_ovf = !t_val[TW-1] && (t_val >= T_LIMIT);

  // ---------------- exp2: 28 conditional root multiplies ----------------
  logic [XS:0]   ex_vld_q;
  logic [XS:0]   ex_last_q;
  logic [XS:0]   ex_zero_q;
  logic [XS:0]   ex_ovf_q;
  logic [IW-1:0] ex_ip_q   [XS+1];
  logic [FB-1:0] ex_frac_q [XS];
  logic [MW-1:0] ex_v_q    [XS];   // value after root step i is held in entry i-1
  logic [MW-1:0] ex_step_v [XS];

  for (genvar i = 1; i <= XS; i++) begin : g_exp
    localparam logic [MW-1:0] ROOT = ntgf_pkg::ntgf_root_q30(i);
    logic [MW-1:0]   v_in;
    logic [2*MW-1:0] prod;
    if (i == 1) begin : g_first
      assign v_in = ntgf_pkg::ONE_Q30;
    end else begin : g_rest
      assign v_in = ex_v_q[i-2];
    end
    assign prod         = v_in * ROOT;
    assign ex_step_v[i-1] = ex_frac_q[i-1][FB-i] ? prod[MW+29:30] : v_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q <= '0;
    end else if (en) begin
      ex_vld_q <= {ex_vld_q[XS-1:0], p_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex_last_q    <= {ex_last_q[XS-1:0], p_last_q};
      ex_zero_q    <= {ex_zero_q[XS-1:0], p_zero_q};
      ex_ovf_q     <= {ex_ovf_q[XS-1:0], t_ovf};
      ex_ip_q[0]   <= t_val[FB+IW-1:FB];
      ex_frac_q[0] <= t_val[FB-1:0];
      for (int i = 1; i <= int'(XS); i++) begin
        ex_ip_q[i]  <= ex_ip_q[i-1];
        ex_v_q[i-1] <= ex_step_v[i-1];
        if (i < int'(XS)) ex_frac_q[i] <= ex_frac_q[i-1];
      end
    end
  end

  // ---------------- final scaling and special cases ----------------
  logic signed [IW-1:0] f_ip;
  logic [MW-1:0]        f_v;
  logic [IW:0]          f_shift;
  logic [39:0]          f_rnd;
  logic [31:0]          f_gain;
  ntgf_pkg::ntgf_out_t  res;

  assign f_ip    = $signed(ex_ip_q[XS]);
  assign f_v     = ex_v_q[XS-1];
  assign f_shift = (IW+1)'(30) - {f_ip[IW-1], f_ip};
  assign f_rnd   = ({9'd0, f_v} + (40'd1 << (f_shift - 1'b1))) >> f_shift;

  always_comb begin
    if (f_ip == IW'(31)) begin
      f_gain = {f_v, 1'b0};
    end else if (f_ip == IW'(30)) begin
      f_gain = {1'b0, f_v};
    end else begin
      f_gain = f_rnd[31:0];
    end
  end

  always_comb begin
    res.last_out  = ex_last_q[XS];
    res.saturated = 1'b0;
    priority if (k_zero) begin
      res.gain = ntgf_pkg::GAIN_ONE;
    end else if (ex_zero_q[XS]) begin
      // zero frequency: gain goes to zero or to infinity depending on the sign of k
      res.gain      = k_neg ? ntgf_pkg::GAIN_MAX : '0;
      res.saturated = k_neg;
    end else if (ex_ovf_q[XS]) begin
      res.gain      = ntgf_pkg::GAIN_MAX;
      res.saturated = 1'b1;
    end else begin
      res.gain = f_gain;
    end
  end

  // ---------------- output register and skid ----------------
  logic                out_vld_q;
  ntgf_pkg::ntgf_out_t out_q;
  ntgf_pkg::ntgf_out_t skid_q;
  logic                out_take;
  logic                incoming;

  assign out_take = out_vld_q && !out_stall_i;
  assign incoming = en && ex_vld_q[XS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) skid_vld_q <= 1'b0;
    end else if (incoming) begin
      if (out_vld_q && !out_take) skid_vld_q <= 1'b1;
      else                        out_vld_q  <= 1'b1;
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) out_q <= skid_q;
    end else if (incoming) begin
      if (out_vld_q && !out_take) skid_q <= res;
      else                        out_q  <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

### hw/rtl/ntgf_checker.sv
// Port-level checker for the spectral tilt gain unit, bound to the top level.
// Depends on ntgf_pkg.
`default_nettype none

module ntgf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input ntgf_pkg::ntgf_in_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ntgf_pkg::ntgf_out_t out_item_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [1:0]          cfg_index_i
);

  // A stalled input item stays put.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("input item changed or dropped while stalled");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed or dropped while stalled");

  // The saturation flag only comes with a pinned gain.
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.saturated |-> out_item_o.gain == ntgf_pkg::GAIN_MAX)
    else $error("saturated item without maximum gain");

  // log2(center) is rebuilt after reset; no item may enter meanwhile.
  a_reset_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("item accepted before log2(center) was ready");

  // A new center forces a rebuild of log2(center).
  a_center_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_index_i == ntgf_pkg::CFG_CENTER) |=> in_stall_o)
    else $error("input open right after a center write");

endmodule

bind noise_tilt_gain_from_frequency_unit ntgf_checker u_ntgf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_index_i (cfg_index_i)
);

`default_nettype wire

### bench/tilt_gain_checker.sv
// Checker for the spectral tilt gain unit: tracks register writes, predicts each gain
// in fixed point and compares every output item in order. Uses ntgf_pkg types.
`timescale 1ns / 100ps

module tilt_gain_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ntgf_pkg::ntgf_in_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ntgf_pkg::ntgf_out_t out_item_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [23:0]         cfg_data_i,
  output int                  pending_o,
  output int                  fail_count_o
);

  localparam longint ARG_ONE    = longint'(1) << 28;  // 1.0 in Q28
  localparam longint SAT_ARG    = 32 * ARG_ONE;
  localparam longint GAIN_SCALE = 16 * ARG_ONE;       // Q16.16 output scale
  localparam longint ARG_FLOOR  = -64 * ARG_ONE;
  localparam longint K_HALF     = longint'(1) << 29;
  localparam longint K_ONE      = longint'(1) << 30;
  localparam longint K_TILT45   = 802550955;
  localparam logic [31:0] UNITY_GAIN = 32'h0001_0000;
  localparam logic [31:0] FULL_GAIN  = 32'hFFFF_FFFF;
  localparam logic [23:0] CENTER_AT_RESET = 24'd16000;

  logic [23:0] center_q;
  logic [2:0]  env_q;
  logic        rev_q;
  logic [63:0] root_q [0:28];   // 2^(2^-i) in Q30, chained truncated roots
  ntgf_pkg::ntgf_out_t expected_gains [$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] a);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] probe;
    rem   = a;
    r     = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= r + probe) begin
        rem = rem - (r + probe);
        r   = (r >> 1) + probe;
      end else begin
        r = r >> 1;
      end
      probe = probe >> 2;
    end
    return r;
  endfunction

  // log2 in Q28 by repeated squaring of the Q30 mantissa
  function automatic logic [63:0] log2_fix(input logic [23:0] x);
    int          lead;
    logic [63:0] m;
    logic [63:0] acc;
    lead = 0;
    for (int i = 1; i < 24; i++) begin
      if (x[i]) lead = i;
    end
    m   = 64'(x) << (30 - lead);
    acc = 64'(lead) << 28;
    for (int b = 27; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m      = m >> 1;
        acc[b] = 1'b1;
      end
    end
    return acc;
  endfunction

  function automatic ntgf_pkg::ntgf_out_t predict_tilt_gain(input ntgf_pkg::ntgf_in_t pt);
    ntgf_pkg::ntgf_out_t r;
    longint      kq;
    longint      d;
    longint      t;
    longint      ipart;
    longint      shamt;
    logic [23:0] center;
    logic [63:0] dm;
    logic [63:0] km;
    logic [63:0] em;
    logic [63:0] tt;
    logic [63:0] v;
    logic [63:0] g;
    logic        neg;
    r.gain      = UNITY_GAIN;
    r.saturated = 1'b0;
    r.last_out  = pt.last_point;
    center      = (center_q == '0) ? 24'd1 : center_q;
    case (env_q)
      ntgf_pkg::ENV_PINK:    kq = -K_HALF;
      ntgf_pkg::ENV_BROWN:   kq = -K_ONE;
      ntgf_pkg::ENV_BLUE:    kq = K_HALF;
      ntgf_pkg::ENV_VIOLET:  kq = K_ONE;
      ntgf_pkg::ENV_PLUS45:  kq = K_TILT45;
      ntgf_pkg::ENV_MINUS45: kq = -K_TILT45;
      default:               kq = 0;
    endcase
    if (rev_q) kq = -kq;

    if (kq == 0) begin
      r.gain = UNITY_GAIN;
    end else if (pt.frequency == '0) begin
      if (kq > 0) begin
        r.gain = '0;
      end else begin
        r.gain      = FULL_GAIN;
        r.saturated = 1'b1;
      end
    end else begin
      d   = longint'(log2_fix(pt.frequency)) - longint'(log2_fix(center));
      neg = (d < 0) != (kq < 0);
      dm  = (d < 0) ? -d : d;
      km  = (kq < 0) ? -kq : kq;
      em  = (dm * km + (64'd1 << 29)) >> 30;
      t   = (neg ? -longint'(em) : longint'(em)) + GAIN_SCALE;
      if (t >= SAT_ARG) begin
        r.gain      = FULL_GAIN;
        r.saturated = 1'b1;
      end else begin
        if (t < ARG_FLOOR) t = ARG_FLOOR;
        tt    = t - ARG_FLOOR;
        ipart = longint'(tt >> 28) - 64;
        v     = 64'd1 << 30;
        for (int i = 1; i <= 28; i++) begin
          if (tt[28 - i]) v = (v * root_q[i]) >> 30;
        end
        if (ipart >= 31) begin
          g = v << 1;
        end else if (ipart == 30) begin
          g = v;
        end else begin
          shamt = 30 - ipart;
          if (shamt > 40) g = '0;
          else g = (v + (64'd1 << (shamt - 1))) >> shamt;
        end
        if (g > 64'(FULL_GAIN)) begin
          r.gain      = FULL_GAIN;
          r.saturated = 1'b1;
        end else begin
          r.gain = g[31:0];
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    center_q     = CENTER_AT_RESET;
    env_q        = ntgf_pkg::ENV_WHITE;
    rev_q        = 1'b0;
    root_q[0]    = 64'd1 << 31;
    for (int i = 1; i <= 28; i++) root_q[i] = int_sqrt(root_q[i-1] << 30);
  end

  always @(posedge clk_i) begin
    ntgf_pkg::ntgf_out_t want;
    if (!rst_ni) begin
      center_q = CENTER_AT_RESET;
      env_q    = ntgf_pkg::ENV_WHITE;
      rev_q    = 1'b0;
      expected_gains.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ntgf_pkg::CFG_CENTER:   center_q = cfg_data_i;
          ntgf_pkg::CFG_ENVELOPE: env_q    = cfg_data_i[2:0];
          ntgf_pkg::CFG_REVERSE:  rev_q    = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_gains.push_back(predict_tilt_gain(in_item_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_gains.size() == 0) begin
          report_mismatch("gain item with none expected", out_item_i.gain, '0);
        end else begin
          want = expected_gains.pop_front();
          if (out_item_i.gain !== want.gain)
            report_mismatch("gain", out_item_i.gain, want.gain);
          if (out_item_i.saturated !== want.saturated)
            report_mismatch("saturated", out_item_i.saturated, want.saturated);
          if (out_item_i.last_out !== want.last_out)
            report_mismatch("last_out", out_item_i.last_out, want.last_out);
        end
      end
    end
    pending_o = expected_gains.size();
  end

endmodule

### bench/noise_tilt_gain_from_frequency_unit_tb.sv
// Top of the spectral tilt gain unit testbench: clock, reset, register writes,
// frequency stimulus and output stalls. Needs ntgf_pkg and tilt_gain_checker.
`timescale 1ns / 100ps

module noise_tilt_gain_from_frequency_unit_tb;

  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 1830;
  localparam int DRAIN_CYCLES  = 70;
  localparam logic [23:0] FREQ_MAX = 24'hFF_FFFF;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  ntgf_pkg::ntgf_in_t      in_item_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  ntgf_pkg::ntgf_out_t     out_item_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  ntgf_pkg::ntgf_cfg_idx_e cfg_index_i;
  logic [23:0]             cfg_data_i;

  int   pending;
  int   fail_count;
  int   quiet_cycles;
  bit   tx_burst;
  bit   rx_burst;
  bit   hold_off_req;

  noise_tilt_gain_from_frequency_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  tilt_gain_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Any accepted item or register write resets the quiet count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output side: a random stall before each item, or one long hold-off on request.
  initial begin
    int wait_cycles;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      wait_cycles = rx_burst ? 0 : $urandom_range(0, 11);
      if (hold_off_req) begin
        wait_cycles  = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (wait_cycles > 0) begin
        out_stall_i = 1'b1;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // All tasks start and end at a falling edge.
  task automatic send_point(input logic [23:0] freq, input logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i.frequency  = freq;
    in_item_i.last_point = last;
    in_valid_i           = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input ntgf_pkg::ntgf_cfg_idx_e idx, input logic [23:0] data);
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Unused upper data bits are filled with noise; only the low bits count.
  task automatic apply_config(input logic [23:0] center, input logic [2:0] env,
                              input logic rev);
    wait_drained();
    write_reg(ntgf_pkg::CFG_CENTER, center);
    write_reg(ntgf_pkg::CFG_ENVELOPE, {21'($urandom), env});
    write_reg(ntgf_pkg::CFG_REVERSE, {23'($urandom), rev});
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    int          sent;
    int          n_points;
    int          phase;
    int          width;
    logic [23:0] center;
    logic [23:0] freq;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = ntgf_pkg::CFG_CENTER;
    cfg_data_i   = '0;
    tx_burst     = 1'b0;
    rx_burst     = 1'b0;
    hold_off_req = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: white, every frequency gives unity
    send_point(24'd0, 1'b0);
    send_point(FREQ_MAX, 1'b1);
    send_point(24'd16000, 1'b0);
    // violet at center 1: zero gives 0, top frequency overflows
    apply_config(24'd1, ntgf_pkg::ENV_VIOLET, 1'b0);
    send_point(24'd0, 1'b1);
    send_point(24'd1, 1'b0);
    send_point(FREQ_MAX, 1'b1);
    send_point(24'd65535, 1'b0);
    // brown at top center: zero and low frequencies saturate
    apply_config(FREQ_MAX, ntgf_pkg::ENV_BROWN, 1'b0);
    send_point(24'd0, 1'b0);
    send_point(24'd1, 1'b1);
    send_point(FREQ_MAX, 1'b0);
    // brown at center 1: gain far below one LSB rounds to zero
    apply_config(24'd1, ntgf_pkg::ENV_BROWN, 1'b0);
    send_point(FREQ_MAX, 1'b1);
    // unused envelope code behaves as white
    apply_config(24'd3000, 3'd7, 1'b1);
    send_point(24'd12345, 1'b0);
    // reversed pink with a zero center
    apply_config(24'd0, ntgf_pkg::ENV_PINK, 1'b1);
    send_point(24'd0, 1'b1);
    send_point(24'd4, 1'b0);
    send_point(FREQ_MAX, 1'b1);
    apply_config(24'd16000, ntgf_pkg::ENV_PLUS45, 1'b0);
    send_point(24'd32000, 1'b0);
    send_point(24'd8000, 1'b1);
    apply_config(24'd16000, ntgf_pkg::ENV_MINUS45, 1'b1);
    send_point(24'd4000, 1'b0);
    apply_config(24'd1000, ntgf_pkg::ENV_BLUE, 1'b0);
    send_point(24'd250, 1'b1);
    send_point(24'd0, 1'b0);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       center = 24'd1;
        1:       center = FREQ_MAX;
        2:       center = 24'd0;
        3:       center = 24'd16000;
        default: begin
          width  = $urandom_range(1, 24);
          center = 24'($urandom & ((32'd1 << width) - 1));
        end
      endcase
      apply_config(center, 3'($urandom_range(0, 7)), 1'($urandom));
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      n_points = $urandom_range(20, 100);
      // one phase fills the pipeline behind a long output hold-off
      if (phase == 1) begin
        tx_burst     = 1'b1;
        n_points     = 180;
        hold_off_req = 1'b1;
      end
      for (int k = 0; k < n_points; k++) begin
        case ($urandom_range(0, 9))
          0: freq = 24'd0;
          1: freq = FREQ_MAX;
          2: freq = 24'd1;
          3: freq = center;
          4: freq = $urandom_range(0, 1) ? center << $urandom_range(1, 4)
                                         : center >> $urandom_range(1, 4);
          5, 6: begin
            width = $urandom_range(1, 24);
            freq  = 24'($urandom & ((32'd1 << width) - 1));
          end
          default: freq = 24'($urandom);
        endcase
        send_point(freq, (k == n_points - 1) || ($urandom_range(0, 7) == 0));
      end
      sent  += n_points;
      phase++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ntgf_pkg.sv
hw/rtl/noise_tilt_gain_from_frequency_unit.sv
hw/rtl/ntgf_checker.sv
bench/tilt_gain_checker.sv
bench/noise_tilt_gain_from_frequency_unit_tb.sv
